### design/exptok_pkg.sv
// shared token types, character constants and character classes for the expression tokenizer
package exptok_pkg;

   localparam int MAX_TOKENS = 4;

   typedef enum logic [4:0] {
      K_PLUS, K_MINUS, K_STAR, K_SLASH, K_CARET, K_LPAREN, K_RPAREN,
      K_LBRACE, K_RBRACE, K_COLON, K_COMMA, K_EQUALS, K_AT, K_SEMICOLON,
      K_STRING, K_HEXCOLOR, K_DOTDOT, K_DOT, K_NUMBER, K_IDENT, K_ERROR, K_EOF
   } kind_type;

   // kind sits in the lowest bits, column in the highest
   typedef struct packed {
      logic [15:0] column;
      logic [15:0] line;
      logic [15:0] length;
      logic [15:0] start_res;
      kind_type    kind;
   } tok_type;

   typedef struct packed {
      logic [2:0]                   count;
      tok_type [MAX_TOKENS-1:0]     toks;
   } batch_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_E_LO   = "e";
   localparam logic [7:0] CH_E_UP   = "E";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_AT     = "@";
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_single(logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == "*") || (c == "/") ||
             (c == "^") || (c == "(") || (c == ")") || (c == "{") || (c == "}") ||
             (c == ":") || (c == ",") || (c == "=") || (c == CH_AT) || (c == ";");
   endfunction

   function automatic kind_type single_kind(logic [7:0] c);
      kind_type k;
      case (c)
         CH_PLUS:  k = K_PLUS;
         CH_MINUS: k = K_MINUS;
         "*":      k = K_STAR;
         "/":      k = K_SLASH;
         "^":      k = K_CARET;
         "(":      k = K_LPAREN;
         ")":      k = K_RPAREN;
         "{":      k = K_LBRACE;
         "}":      k = K_RBRACE;
         ":":      k = K_COLON;
         ",":      k = K_COMMA;
         "=":      k = K_EQUALS;
         CH_AT:    k = K_AT;
         ";":      k = K_SEMICOLON;
         default:  k = K_ERROR;
      endcase
      return k;
   endfunction

endpackage

### design/expression_tokenizer.sv
// expression tokenizer top level: input handshake, scan core and token output buffer
// the first token of a byte is registered and offered on rsp in the cycle after the byte is accepted
// one byte per cycle while each byte yields at most one token and rsp_tready is high; a byte that
//    yields n tokens (up to four) holds req until its tokens leave the single read port of the buffer
// a new byte is taken in the cycle the last buffered token of the previous byte is taken
// reset (synchronous): position 0, line 1, column 1, idle scan, buffered tokens dropped
module expression_tokenizer #(
   parameter int POS_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // ch
   input  logic         req_tuser,   // has_char
   input  logic         req_tlast,   // end_of_source
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // kind, start_res, length, line, column, zero pad
   output logic         rsp_tlast    // last_of_run
);
   import exptok_pkg::*;

   localparam int TOK_BITS = $bits(tok_type);

   batch_type                 batch;
   tok_type [MAX_TOKENS-1:0]  tok_ff, tok_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic [1:0]                rd_ff, rd_in;
   logic                      req_accept;
   logic                      rsp_accept;

   exptok_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .ch            (req_tdata),
      .has_char      (req_tuser),
      .end_of_source (req_tlast),
      .batch         (batch)
   );

   assign req_tready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {(72 - TOK_BITS)'(0), tok_ff[rd_ff]};
   assign rsp_tlast  = (cnt_ff == 3'd1);

   always_comb begin
      tok_in = tok_ff;
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (req_accept) begin
         tok_in = batch.toks;
         cnt_in = batch.count;
         rd_in  = 2'd0;
      end else if (rsp_accept) begin
         cnt_in = cnt_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         rd_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      tok_ff <= tok_in;
   end

`ifndef ASSERT_OFF
   a_eos_ends_with_eof: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |-> batch.count != 3'd0 &&
                                  batch.toks[batch.count[1:0] - 2'd1].kind == K_EOF)
      else $error("end of source transaction without a closing eof token");
   a_load_batch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> cnt_ff == $past(batch.count) && rd_ff == 2'd0)
      else $error("token buffer not loaded from accepted transaction");
   a_read_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && cnt_ff > 3'd1 |=> rd_ff == $past(rd_ff) + 2'd1 &&
                                       cnt_ff == $past(cnt_ff) - 3'd1)
      else $error("token buffer read pointer did not advance");
`endif

endmodule

### design/exptok_core.sv
// scan state registers and the per-byte token decision logic
module exptok_core #(
   parameter int POS_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             ch,
   input  logic                   has_char,
   input  logic                   end_of_source,
   output exptok_pkg::batch_type  batch
);
   import exptok_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_INTDOT, M_FRAC, M_EXPSTART, M_EXPDIG,
      M_STRING, M_ESCAPE, M_HEX, M_DOT
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic                  quote;
      logic [POS_BITS-1:0]   tstart;
      logic [POS_BITS-1:0]   pos;
      logic [15:0]           line;
      logic [15:0]           col;
   } scan_type;

   typedef struct packed {
      scan_type   s;
      batch_type  b;
   } work_type;

   localparam logic [POS_BITS-1:0] POS_MAX  = '1;
   localparam logic [POS_BITS-1:0] POS_ZERO = '0;
   localparam logic [POS_BITS-1:0] POS_ONE  = POS_BITS'(1);
   localparam logic [15:0]         CNT_MAX  = 16'hFFFF;
   localparam scan_type SCAN_RESET = '{mode: M_IDLE, quote: 1'b0, tstart: POS_ZERO,
                                       pos: POS_ZERO, line: 16'd1, col: 16'd1};

   scan_type st_ff, st_in;
   work_type work;

   function automatic work_type bump(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      if (r.s.pos != POS_MAX) r.s.pos = r.s.pos + POS_ONE;
      if (c == CH_LF) begin
         if (r.s.line != CNT_MAX) r.s.line = r.s.line + 16'd1;
         r.s.col = 16'd1;
      end else if (r.s.col != CNT_MAX) begin
         r.s.col = r.s.col + 16'd1;
      end
      return r;
   endfunction

   function automatic work_type emit(work_type w, kind_type k,
                                     logic [POS_BITS-1:0] start,
                                     logic [POS_BITS-1:0] len_raw);
      work_type    r;
      tok_type     t;
      logic [31:0] s32;
      logic [31:0] l32;
      r   = w;
      s32 = 32'(start);
      l32 = 32'(len_raw);
      t.kind      = k;
      t.start_res = s32[15:0];
      t.length    = (l32 > 32'h0000_FFFF) ? 16'hFFFF : l32[15:0];
      t.line      = r.s.line;
      t.column    = r.s.col - t.length;
      if (r.b.count < 3'(MAX_TOKENS)) begin
         r.b.toks[r.b.count[1:0]] = t;
         r.b.count = r.b.count + 3'd1;
      end
      return r;
   endfunction

   function automatic work_type emit_open(work_type w, kind_type k);
      return emit(w, k, w.s.tstart, w.s.pos - w.s.tstart);
   endfunction

   function automatic work_type scan_idle(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      r.s.mode = M_IDLE;
      if (is_space(c)) begin
         r = bump(r, c);
      end else begin
         r.s.tstart = r.s.pos;
         if (is_single(c)) begin
            r = bump(r, c);
            r = emit_open(r, single_kind(c));
         end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            r.s.quote  = (c == CH_SQUOTE);
            r          = bump(r, c);
            r.s.tstart = r.s.pos;
            r.s.mode   = M_STRING;
         end else begin
            r = bump(r, c);
            if (c == CH_HASH) r.s.mode = M_HEX;
            else if (c == CH_DOT) r.s.mode = M_DOT;
            else if (is_digit(c)) r.s.mode = M_INT;
            else if (is_alpha(c) || (c == CH_UNDER)) r.s.mode = M_IDENT;
            else r = emit_open(r, K_ERROR);
         end
      end
      return r;
   endfunction

   // number ends before a held dot, the dot opens its own token
   function automatic work_type close_before_dot(work_type w);
      work_type r;
      r          = emit_open(w, K_NUMBER);
      r.s.tstart = r.s.pos;
      r          = bump(r, CH_DOT);
      return r;
   endfunction

   function automatic work_type scan_byte(work_type w, logic [7:0] c);
      work_type   r;
      logic [7:0] quote_ch;
      r        = w;
      quote_ch = r.s.quote ? CH_SQUOTE : CH_DQUOTE;
      case (r.s.mode)
         M_IDENT: begin
            if (is_word(c)) r = bump(r, c);
            else r = scan_idle(emit_open(r, K_IDENT), c);
         end
         M_INT: begin
            if (is_digit(c)) begin
               r = bump(r, c);
            end else if (c == CH_DOT) begin
               r.s.mode = M_INTDOT;
            end else if ((c == CH_E_LO) || (c == CH_E_UP)) begin
               r        = bump(r, c);
               r.s.mode = M_EXPSTART;
            end else begin
               r = scan_idle(emit_open(r, K_NUMBER), c);
            end
         end
         M_INTDOT: begin
            if (is_digit(c)) begin
               r        = bump(bump(r, CH_DOT), c);
               r.s.mode = M_FRAC;
            end else if (c == CH_DOT) begin
               r        = bump(close_before_dot(r), c);
               r        = emit_open(r, K_DOTDOT);
               r.s.mode = M_IDLE;
            end else begin
               r = emit_open(close_before_dot(r), K_DOT);
               r = scan_idle(r, c);
            end
         end
         M_FRAC: begin
            if (is_digit(c)) begin
               r = bump(r, c);
            end else if ((c == CH_E_LO) || (c == CH_E_UP)) begin
               r        = bump(r, c);
               r.s.mode = M_EXPSTART;
            end else begin
               r = scan_idle(emit_open(r, K_NUMBER), c);
            end
         end
         M_EXPSTART: begin
            if ((c == CH_PLUS) || (c == CH_MINUS) || is_digit(c)) begin
               r        = bump(r, c);
               r.s.mode = M_EXPDIG;
            end else begin
               r = scan_idle(emit_open(r, K_NUMBER), c);
            end
         end
         M_EXPDIG: begin
            if (is_digit(c)) r = bump(r, c);
            else r = scan_idle(emit_open(r, K_NUMBER), c);
         end
         M_STRING: begin
            if (c == quote_ch) begin
               r        = bump(emit_open(r, K_STRING), c);
               r.s.mode = M_IDLE;
            end else if (c == CH_NUL) begin
               r = scan_idle(emit_open(r, K_STRING), c);
            end else begin
               r = bump(r, c);
               if (c == CH_BSLASH) r.s.mode = M_ESCAPE;
            end
         end
         M_ESCAPE: begin
            if (c == CH_NUL) begin
               r = scan_idle(emit_open(r, K_STRING), c);
            end else begin
               r        = bump(r, c);
               r.s.mode = M_STRING;
            end
         end
         M_HEX: begin
            if (is_hex(c)) r = bump(r, c);
            else r = scan_idle(emit_open(r, K_HEXCOLOR), c);
         end
         M_DOT: begin
            if (c == CH_DOT) begin
               r        = emit_open(bump(r, c), K_DOTDOT);
               r.s.mode = M_IDLE;
            end else if (is_digit(c)) begin
               r        = bump(r, c);
               r.s.mode = M_FRAC;
            end else begin
               r = scan_idle(emit_open(r, K_DOT), c);
            end
         end
         default: begin
            r = scan_idle(r, c);
         end
      endcase
      return r;
   endfunction

   // close whatever token is open at end of source
   function automatic work_type flush_open(work_type w);
      work_type r;
      r = w;
      case (r.s.mode)
         M_IDENT:                              r = emit_open(r, K_IDENT);
         M_INT, M_FRAC, M_EXPSTART, M_EXPDIG:  r = emit_open(r, K_NUMBER);
         M_INTDOT:                             r = emit_open(close_before_dot(r), K_DOT);
         M_STRING, M_ESCAPE:                   r = emit_open(r, K_STRING);
         M_HEX:                                r = emit_open(r, K_HEXCOLOR);
         M_DOT:                                r = emit_open(r, K_DOT);
         default:                              r = w;
      endcase
      r.s.mode = M_IDLE;
      return r;
   endfunction

   always_comb begin
      work.s = st_ff;
      work.b = '0;
      if (has_char) work = scan_byte(work, ch);
      if (end_of_source) begin
         work   = flush_open(work);
         work   = emit(work, K_EOF, work.s.pos, POS_ZERO);
         work.s = SCAN_RESET;
      end
      st_in = work.s;
      batch = work.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SCAN_RESET;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

`ifndef ASSERT_OFF
   a_eos_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_source |=> st_ff.mode == M_IDLE && st_ff.pos == POS_ZERO &&
                                  st_ff.line == 16'd1 && st_ff.col == 16'd1)
      else $error("scan state not rearmed after end of source");
   a_start_behind_pos: assert property (@(posedge clock) disable iff (reset)
      st_ff.tstart <= st_ff.pos)
      else $error("token start ahead of byte position");
   a_counts_nonzero: assert property (@(posedge clock) disable iff (reset)
      st_ff.line != 16'd0 && st_ff.col != 16'd0)
      else $error("line or column counter reached zero");
`endif

endmodule

### dv/tb_top.sv
// self-checking testbench for the expression tokenizer: directed table and random runs
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import exptok_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef enum {
      SC_IDLE, SC_WORD, SC_INT, SC_INT_DOT, SC_FRAC, SC_EXP_MARK, SC_EXP_DIGITS,
      SC_QUOTED, SC_QUOTED_ESC, SC_HEX, SC_DOT
   } scan_state_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] start_res;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      bit          last;
   } token_rec_type;

   typedef struct {
      logic [7:0] ch;
      bit         has;
      bit         eos;
   } src_item_type;

   typedef struct {
      src_item_type  item;
      bit            pinned;
      token_rec_type tok;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // ch
   logic        req_tuser = 1'b0;    // has_char
   logic        req_tlast = 1'b0;    // end_of_source
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // kind, start_res, length, line, column, zero pad
   logic        rsp_tlast;           // last_of_run
   tok_type     rsp_tok;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   token_rec_type pending_tokens[$];
   src_item_type  source_text[$];
   table_row_type directed_rows[$];

   // scanner state mirrored by the predictor
   scan_state_type mode;
   bit             quote_single;
   logic [15:0]    tok_start;
   logic [15:0]    pos;
   logic [15:0]    line_no;
   logic [15:0]    col_no;
   int             run_count;

   expression_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tok = rsp_tdata[68:0];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("expression_tokenizer test failed");
         $finish;
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : token_monitor
      token_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d start %0d length %0d",
                   rsp_tok.kind, rsp_tok.start_res, rsp_tok.length);
            failures++;
         end else begin
            want = pending_tokens.pop_front();
            check_field("kind", want.kind, rsp_tok.kind);
            check_field("start_res", want.start_res, rsp_tok.start_res);
            check_field("length", want.length, rsp_tok.length);
            check_field("line", want.line, rsp_tok.line);
            check_field("column", want.column, rsp_tok.column);
            check_field("last_of_run", want.last, rsp_tlast);
         end
      end
   end

   // ---------------- token predictor ----------------

   function automatic bit digit_ch(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic bit letter_ch(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
   endfunction

   task automatic reset_scan();
      mode = SC_IDLE;
      quote_single = 1'b0;
      tok_start = '0;
      pos = '0;
      line_no = 16'd1;
      col_no = 16'd1;
   endtask

   task automatic advance(input logic [7:0] c);
      if (pos != 16'hFFFF) pos++;
      if (c == CH_LF) begin
         if (line_no != 16'hFFFF) line_no++;
         col_no = 16'd1;
      end else if (col_no != 16'hFFFF) begin
         col_no++;
      end
   endtask

   task automatic push_token(input kind_type k, input logic [15:0] start, input logic [15:0] len);
      token_rec_type t;
      t.kind = k;
      t.start_res = start;
      t.length = len;
      t.line = line_no;
      t.column = col_no - len;
      t.last = 1'b0;
      pending_tokens.insert(pending_tokens.size(), t);
      run_count++;
   endtask

   task automatic close_open(input kind_type k);
      push_token(k, tok_start, pos - tok_start);
   endtask

   // integer part ends before a held dot, which then opens its own token
   task automatic split_number();
      close_open(K_NUMBER);
      tok_start = pos;
      advance(CH_DOT);
   endtask

   task automatic scan_fresh(input logic [7:0] c);
      kind_type k;
      bit       is_punct;
      mode = SC_IDLE;
      is_punct = 1'b1;
      case (c)
         "+":     k = K_PLUS;
         "-":     k = K_MINUS;
         "*":     k = K_STAR;
         "/":     k = K_SLASH;
         "^":     k = K_CARET;
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         ":":     k = K_COLON;
         ",":     k = K_COMMA;
         "=":     k = K_EQUALS;
         "@":     k = K_AT;
         ";":     k = K_SEMICOLON;
         default: begin
            k = K_ERROR;
            is_punct = 1'b0;
         end
      endcase
      if (c == " " || c inside {[8'h09:8'h0D]}) begin
         advance(c);
      end else begin
         tok_start = pos;
         if (is_punct) begin
            advance(c);
            close_open(k);
         end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            quote_single = (c == CH_SQUOTE);
            advance(c);
            tok_start = pos;
            mode = SC_QUOTED;
         end else begin
            advance(c);
            if (c == CH_HASH) mode = SC_HEX;
            else if (c == CH_DOT) mode = SC_DOT;
            else if (digit_ch(c)) mode = SC_INT;
            else if (letter_ch(c) || c == CH_UNDER) mode = SC_WORD;
            else close_open(K_ERROR);
         end
      end
   endtask

   task automatic tokenize_byte(input logic [7:0] c);
      logic [7:0] quote;
      quote = quote_single ? CH_SQUOTE : CH_DQUOTE;
      case (mode)
         SC_WORD: begin
            if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) advance(c);
            else begin
               close_open(K_IDENT);
               scan_fresh(c);
            end
         end
         SC_INT: begin
            if (digit_ch(c)) advance(c);
            else if (c == CH_DOT) mode = SC_INT_DOT;
            else if (c == CH_E_LO || c == CH_E_UP) begin
               advance(c);
               mode = SC_EXP_MARK;
            end else begin
               close_open(K_NUMBER);
               scan_fresh(c);
            end
         end
         SC_INT_DOT: begin
            if (digit_ch(c)) begin
               advance(CH_DOT);
               advance(c);
               mode = SC_FRAC;
            end else if (c == CH_DOT) begin
               split_number();
               advance(c);
               close_open(K_DOTDOT);
               mode = SC_IDLE;
            end else begin
               split_number();
               close_open(K_DOT);
               scan_fresh(c);
            end
         end
         SC_FRAC: begin
            if (digit_ch(c)) advance(c);
            else if (c == CH_E_LO || c == CH_E_UP) begin
               advance(c);
               mode = SC_EXP_MARK;
            end else begin
               close_open(K_NUMBER);
               scan_fresh(c);
            end
         end
         SC_EXP_MARK: begin
            if (c == CH_PLUS || c == CH_MINUS || digit_ch(c)) begin
               advance(c);
               mode = SC_EXP_DIGITS;
            end else begin
               close_open(K_NUMBER);
               scan_fresh(c);
            end
         end
         SC_EXP_DIGITS: begin
            if (digit_ch(c)) advance(c);
            else begin
               close_open(K_NUMBER);
               scan_fresh(c);
            end
         end
         SC_QUOTED: begin
            if (c == quote) begin
               close_open(K_STRING);
               advance(c);
               mode = SC_IDLE;
            end else if (c == CH_NUL) begin
               close_open(K_STRING);
               scan_fresh(c);
            end else begin
               advance(c);
               if (c == CH_BSLASH) mode = SC_QUOTED_ESC;
            end
         end
         SC_QUOTED_ESC: begin
            if (c == CH_NUL) begin
               close_open(K_STRING);
               scan_fresh(c);
            end else begin
               advance(c);
               mode = SC_QUOTED;
            end
         end
         SC_HEX: begin
            if (digit_ch(c) || c inside {["a":"f"], ["A":"F"]}) advance(c);
            else begin
               close_open(K_HEXCOLOR);
               scan_fresh(c);
            end
         end
         SC_DOT: begin
            if (c == CH_DOT) begin
               advance(c);
               close_open(K_DOTDOT);
               mode = SC_IDLE;
            end else if (digit_ch(c)) begin
               advance(c);
               mode = SC_FRAC;
            end else begin
               close_open(K_DOT);
               scan_fresh(c);
            end
         end
         default: scan_fresh(c);
      endcase
   endtask

   // expected tokens of one transaction go to the back of pending_tokens
   task automatic predict_item(input logic [7:0] ch, input bit has, input bit eos, output int n);
      run_count = 0;
      if (has) tokenize_byte(ch);
      if (eos) begin
         case (mode)
            SC_WORD: close_open(K_IDENT);
            SC_INT, SC_FRAC, SC_EXP_MARK, SC_EXP_DIGITS: close_open(K_NUMBER);
            SC_INT_DOT: begin
               split_number();
               close_open(K_DOT);
            end
            SC_QUOTED, SC_QUOTED_ESC: close_open(K_STRING);
            SC_HEX: close_open(K_HEXCOLOR);
            SC_DOT: close_open(K_DOT);
            default: ;
         endcase
         push_token(K_EOF, pos, 16'd0);
         reset_scan();
      end
      if (run_count > 0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
      n = run_count;
   endtask

   // ---------------- stimulus ----------------

   task automatic send_item(input logic [7:0] ch, input bit has, input bit eos, output int n);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tuser <= has;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
      predict_item(ch, has, eos, n);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   task automatic add_row(input logic [7:0] ch, input bit has, input bit eos,
                          input bit pin = 1'b0, input kind_type kind = K_EOF,
                          input logic [15:0] start = 0, input logic [15:0] len = 0,
                          input logic [15:0] ln = 0, input logic [15:0] col = 0);
      table_row_type r;
      r.item.ch = ch;
      r.item.has = has;
      r.item.eos = eos;
      r.pinned = pin;
      r.tok.kind = kind;
      r.tok.start_res = start;
      r.tok.length = len;
      r.tok.line = ln;
      r.tok.column = col;
      r.tok.last = 1'b1;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   function automatic logic [7:0] pick(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic add_byte(input logic [7:0] c);
      src_item_type s;
      s.ch = c;
      s.has = 1'b1;
      s.eos = ($urandom_range(0, 99) < 3);
      source_text.insert(source_text.size(), s);
   endtask

   // mostly well-formed lexemes with random content, some noise and broken ones
   task automatic add_fragment();
      string        letters;
      string        digits;
      logic [7:0]   quote;
      src_item_type s;
      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
      digits = "0123456789";
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            add_byte(pick(letters));
            repeat ($urandom_range(0, 6)) add_byte(pick({letters, digits}));
         end
         4, 5, 6, 7: begin
            if ($urandom_range(0, 4) == 0) add_byte(CH_DOT);
            repeat ($urandom_range(1, 3)) add_byte(pick(digits));
            if ($urandom_range(0, 1) == 1) begin
               add_byte(CH_DOT);
               repeat ($urandom_range(0, 2)) add_byte(pick(digits));
            end
            if ($urandom_range(0, 2) == 0) begin
               add_byte($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
               if ($urandom_range(0, 1) == 1) add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
               repeat ($urandom_range(0, 2)) add_byte(pick(digits));
            end
         end
         8, 9: begin
            quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            add_byte(quote);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 5))
                  0: add_byte(CH_BSLASH);
                  1: add_byte(quote == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                  2: add_byte(8'($urandom_range(1, 255)));
                  default: add_byte(pick(letters));
               endcase
            end
            // some strings stay open
            if ($urandom_range(0, 6) != 0) add_byte(quote);
         end
         10: begin
            add_byte(CH_HASH);
            repeat ($urandom_range(0, 6)) add_byte(pick("0123456789abcdefABCDEF"));
         end
         11, 12, 13: add_byte(pick("+-*/^(){}:,=@;"));
         14: repeat ($urandom_range(1, 3)) add_byte(CH_DOT);
         15, 16: add_byte(($urandom_range(0, 5) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4)));
         17: add_byte(8'($urandom_range(0, 255)));
         18: add_byte(CH_NUL);
         default: begin
            s.ch = 8'($urandom());
            s.has = 1'b0;
            s.eos = 1'($urandom_range(0, 1));
            source_text.insert(source_text.size(), s);
         end
      endcase
      if ($urandom_range(0, 2) == 0) add_byte(8'h20);
   endtask

   initial begin : stimulus
      int           n;
      int           sent;
      src_item_type it;
      int unsigned  idle_plan[4];
      int unsigned  stall_plan[4];
      idle_plan = '{0, 70, 0, 7};
      stall_plan = '{0, 0, 70, 7};

      // error, extreme byte and punctuation right after reset, then an ignored and an end item
      add_row(CH_NUL, 1, 0, 1, K_ERROR, 0, 1, 1, 1);
      add_row(8'hFF, 1, 0, 1, K_ERROR, 1, 1, 1, 2);
      add_row(CH_AT, 1, 0, 1, K_AT, 2, 1, 1, 3);
      add_row(8'h5A, 0, 0);
      add_row(8'hA5, 0, 1, 1, K_EOF, 3, 0, 1, 4);
      // number with fraction and signed exponent, then dot dot
      add_row("1", 1, 0);
      add_row(CH_DOT, 1, 0);
      add_row("5", 1, 0);
      add_row(CH_E_UP, 1, 0);
      add_row(CH_MINUS, 1, 0);
      add_row("9", 1, 0);
      add_row(CH_DOT, 1, 0);
      add_row(CH_DOT, 1, 0);
      // integer followed by a dot that is not a fraction
      add_row("3", 1, 0);
      add_row(CH_DOT, 1, 0);
      add_row("x", 1, 0);
      // escape cut by nul, then single quoted string holding a newline
      add_row(CH_DQUOTE, 1, 0);
      add_row(CH_BSLASH, 1, 0);
      add_row(CH_NUL, 1, 0);
      add_row(CH_SQUOTE, 1, 0);
      add_row(CH_DQUOTE, 1, 0);
      add_row(CH_LF, 1, 0);
      add_row(CH_SQUOTE, 1, 0);
      add_row(CH_HASH, 1, 0);
      add_row("f", 1, 1);
      // integer dot plus at end of source gives four tokens
      add_row(8'h09, 1, 0);
      add_row("7", 1, 0);
      add_row(CH_DOT, 1, 0);
      add_row(CH_PLUS, 1, 1);

      reset_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item.ch, directed_rows[i].item.has,
                   directed_rows[i].item.eos, n);
         if (directed_rows[i].pinned) begin
            repeat (n) void'(pending_tokens.pop_back());
            pending_tokens.insert(pending_tokens.size(), directed_rows[i].tok);
         end
      end
      drain_tokens();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         sent = 0;
         while (sent < 105) begin
            add_fragment();
            while (source_text.size() != 0) begin
               it = source_text.pop_front();
               send_item(it.ch, it.has, it.eos, n);
               if (it.has || it.eos) sent++;
            end
         end
         drain_tokens();
      end

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("expression_tokenizer test passed");
      end else begin
         $display("expression_tokenizer test failed");
      end
      $finish;
   end

endmodule
